// ===== rtl/tcp_opt_pkg.sv =====
// Types, codes and limits shared by the TCP option parser.
package tcp_opt_pkg;

    localparam int MAX_OPTION_BYTES = 40;
    localparam int LEN_W = 6;
    localparam logic [LEN_W-1:0] MAX_OPT_LEN = LEN_W'(MAX_OPTION_BYTES);

    localparam logic [7:0] KIND_EOL    = 8'd0;
    localparam logic [7:0] KIND_NOP    = 8'd1;
    localparam logic [7:0] KIND_MSS    = 8'd2;
    localparam logic [7:0] KIND_WSCALE = 8'd3;
    localparam logic [7:0] KIND_SACKOK = 8'd4;
    localparam logic [7:0] KIND_SACK   = 8'd5;
    localparam logic [7:0] KIND_TS     = 8'd8;
    localparam logic [7:0] KIND_MD5    = 8'd19;

    localparam logic [LEN_W-1:0] SIZE_MSS    = LEN_W'(4);
    localparam logic [LEN_W-1:0] SIZE_WSCALE = LEN_W'(3);
    localparam logic [LEN_W-1:0] SIZE_SACKOK = LEN_W'(2);
    localparam logic [LEN_W-1:0] OPT_HDR_LEN = LEN_W'(2);

    typedef enum logic [3:0] {
        PH_STOP = 4'b0001,
        PH_KIND = 4'b0010,
        PH_LEN  = 4'b0100,
        PH_BODY = 4'b1000
    } phase_t;

    typedef enum logic [3:0] {
        EV_NONE     = 4'd0,
        EV_MSS      = 4'd1,
        EV_WSCALE   = 4'd2,
        EV_SACKPERM = 4'd3,
        EV_SACK     = 4'd4,
        EV_TS       = 4'd5,
        EV_MD5      = 4'd6,
        EV_OTHER    = 4'd7,
        EV_EOL      = 4'd8,
        EV_SILLY    = 4'd9,
        EV_PARTIAL  = 4'd10,
        EV_IGNORED  = 4'd11
    } event_t;

    typedef struct packed {
        event_t      ev;
        logic [15:0] value;
        logic [7:0]  kind;
        logic        done;
    } result_t;

endpackage

// ===== rtl/tcp_option_parser.sv =====
// TCP option area walker: one option byte in, one event out.
//
//  channel | dir | tdata                                   | tuser          | tlast
//  s_axis  | in  | opt_byte[7:0] area_len[13:8] syn[14]    | first_byte     | -
//  m_axis  | out | value[15:0] option_kind[23:16]          | event_res[3:0] | done_res
//
// Each byte is decoded in the cycle it is taken and its event appears on the
// output register in the next cycle; one byte per cycle flows unless stalled.
// The output register is refilled in the cycle its transfer completes, so the
// input only stalls while a result sits untaken (m_axis_tready low).
// Reset clears the walk state and empties the output register.
module tcp_option_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // opt_byte, area_len, syn_flag, 1'b0 pad
    input  logic        s_axis_tuser,   // first_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // value, option_kind
    output logic [3:0]  m_axis_tuser,   // event_res
    output logic        m_axis_tlast    // done_res
);

    localparam int LW = tcp_opt_pkg::LEN_W;

    tcp_opt_pkg::phase_t phase_reg, phase_next;
    logic [LW-1:0]       bytes_left_reg, bytes_left_next;
    logic [7:0]          kind_reg, kind_next;
    logic [LW-1:0]       size_reg, size_next;
    logic [LW-1:0]       body_cnt_reg, body_cnt_next;
    logic [15:0]         value_acc_reg, value_acc_next;
    logic                syn_reg, syn_next;

    logic                out_valid_reg;
    tcp_opt_pkg::result_t res_reg, res_next;

    logic                s_fire;
    logic [7:0]          in_byte;
    logic [LW-1:0]       in_alen, alen_clamped;
    logic                in_syn, in_first;

    assign in_byte  = s_axis_tdata[7:0];
    assign in_alen  = s_axis_tdata[13:8];
    assign in_syn   = s_axis_tdata[14];
    assign in_first = s_axis_tuser;
    assign alen_clamped = (in_alen > tcp_opt_pkg::MAX_OPT_LEN) ?
                          tcp_opt_pkg::MAX_OPT_LEN : in_alen;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // report for a completed option
    function automatic tcp_opt_pkg::result_t finish_opt(
        input logic [7:0]    kind,
        input logic [LW-1:0] size,
        input logic [15:0]   acc,
        input logic          syn,
        input logic [LW-1:0] left
    );
        tcp_opt_pkg::result_t r;
        r.ev    = tcp_opt_pkg::EV_OTHER;
        r.value = 16'(size);
        r.kind  = kind;
        r.done  = (left == '0);
        unique case (kind)
            tcp_opt_pkg::KIND_MSS: begin
                if (size == tcp_opt_pkg::SIZE_MSS && syn) begin
                    r.ev    = tcp_opt_pkg::EV_MSS;
                    r.value = acc;
                end
            end
            tcp_opt_pkg::KIND_WSCALE: begin
                if (size == tcp_opt_pkg::SIZE_WSCALE && syn) begin
                    r.ev    = tcp_opt_pkg::EV_WSCALE;
                    r.value = {8'd0, acc[7:0]};
                end
            end
            tcp_opt_pkg::KIND_SACKOK: begin
                if (size == tcp_opt_pkg::SIZE_SACKOK && syn) begin
                    r.ev = tcp_opt_pkg::EV_SACKPERM;
                end
            end
            tcp_opt_pkg::KIND_SACK: r.ev = tcp_opt_pkg::EV_SACK;
            tcp_opt_pkg::KIND_TS:   r.ev = tcp_opt_pkg::EV_TS;
            tcp_opt_pkg::KIND_MD5:  r.ev = tcp_opt_pkg::EV_MD5;
            default: ;
        endcase
        return r;
    endfunction

    tcp_opt_pkg::phase_t ph;
    logic [LW-1:0]       bl, bl_dec, body_idx, body_dec;
    logic [8:0]          len_limit;

    always_comb begin
        ph = phase_reg;
        bl = bytes_left_reg;
        kind_next      = kind_reg;
        size_next      = size_reg;
        body_cnt_next  = body_cnt_reg;
        value_acc_next = value_acc_reg;
        syn_next       = syn_reg;

        if (in_first) begin
            bl             = alen_clamped;
            syn_next       = in_syn;
            kind_next      = '0;
            size_next      = '0;
            body_cnt_next  = '0;
            value_acc_next = '0;
            ph             = tcp_opt_pkg::PH_KIND;
        end

        bl_dec    = bl - LW'(1);
        len_limit = {3'd0, bl} + 9'd1;
        body_idx  = size_reg - tcp_opt_pkg::OPT_HDR_LEN - body_cnt_reg;
        body_dec  = body_cnt_reg - LW'(1);

        phase_next      = ph;
        bytes_left_next = bl;
        res_next.ev     = tcp_opt_pkg::EV_NONE;
        res_next.value  = '0;
        res_next.kind   = '0;
        res_next.done   = 1'b0;

        if (in_first && alen_clamped == '0) begin
            phase_next    = tcp_opt_pkg::PH_STOP;
            res_next.done = 1'b1;
        end else if (ph == tcp_opt_pkg::PH_STOP || bl == '0) begin
            phase_next    = tcp_opt_pkg::PH_STOP;
            res_next.ev   = tcp_opt_pkg::EV_IGNORED;
            res_next.done = 1'b1;
        end else begin
            unique case (ph)
                tcp_opt_pkg::PH_KIND: begin
                    if (in_byte == tcp_opt_pkg::KIND_EOL) begin
                        phase_next    = tcp_opt_pkg::PH_STOP;
                        res_next.ev   = tcp_opt_pkg::EV_EOL;
                        res_next.done = 1'b1;
                    end else begin
                        bytes_left_next = bl_dec;
                        if (in_byte == tcp_opt_pkg::KIND_NOP) begin
                            res_next.done = (bl_dec == '0);
                            if (bl_dec == '0) phase_next = tcp_opt_pkg::PH_STOP;
                        end else begin
                            kind_next = in_byte;
                            if (bl_dec == '0) begin
                                // area ends right after the kind byte
                                phase_next    = tcp_opt_pkg::PH_STOP;
                                res_next.ev   = tcp_opt_pkg::EV_PARTIAL;
                                res_next.kind = in_byte;
                                res_next.done = 1'b1;
                            end else begin
                                phase_next = tcp_opt_pkg::PH_LEN;
                            end
                        end
                    end
                end
                tcp_opt_pkg::PH_LEN: begin
                    if (in_byte < 8'd2) begin
                        phase_next     = tcp_opt_pkg::PH_STOP;
                        res_next.ev    = tcp_opt_pkg::EV_SILLY;
                        res_next.value = {8'd0, in_byte};
                        res_next.kind  = kind_reg;
                        res_next.done  = 1'b1;
                    end else if ({1'b0, in_byte} > len_limit) begin
                        phase_next     = tcp_opt_pkg::PH_STOP;
                        res_next.ev    = tcp_opt_pkg::EV_PARTIAL;
                        res_next.value = {8'd0, in_byte};
                        res_next.kind  = kind_reg;
                        res_next.done  = 1'b1;
                    end else begin
                        size_next       = in_byte[LW-1:0];
                        body_cnt_next   = in_byte[LW-1:0] - tcp_opt_pkg::OPT_HDR_LEN;
                        value_acc_next  = '0;
                        bytes_left_next = bl_dec;
                        if (body_cnt_next == '0) begin
                            res_next   = finish_opt(kind_reg, size_next, 16'd0,
                                                    syn_reg, bl_dec);
                            phase_next = res_next.done ? tcp_opt_pkg::PH_STOP
                                                       : tcp_opt_pkg::PH_KIND;
                        end else begin
                            phase_next = tcp_opt_pkg::PH_BODY;
                        end
                    end
                end
                tcp_opt_pkg::PH_BODY: begin
                    if (body_idx == '0) begin
                        value_acc_next = {8'd0, in_byte};
                    end else if (body_idx == LW'(1)) begin
                        value_acc_next = {value_acc_reg[7:0], in_byte};
                    end
                    body_cnt_next   = body_dec;
                    bytes_left_next = bl_dec;
                    if (body_dec == '0) begin
                        res_next   = finish_opt(kind_reg, size_reg, value_acc_next,
                                                syn_reg, bl_dec);
                        phase_next = res_next.done ? tcp_opt_pkg::PH_STOP
                                                   : tcp_opt_pkg::PH_KIND;
                    end
                end
                default: begin
                    phase_next = tcp_opt_pkg::PH_STOP;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= tcp_opt_pkg::PH_STOP;
            bytes_left_reg <= '0;
            kind_reg       <= '0;
            size_reg       <= '0;
            body_cnt_reg   <= '0;
            value_acc_reg  <= '0;
            syn_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (s_fire) begin
                phase_reg      <= phase_next;
                bytes_left_reg <= bytes_left_next;
                kind_reg       <= kind_next;
                size_reg       <= size_next;
                body_cnt_reg   <= body_cnt_next;
                value_acc_reg  <= value_acc_next;
                syn_reg        <= syn_next;
                out_valid_reg  <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {res_reg.kind, res_reg.value};
    assign m_axis_tuser  = res_reg.ev;
    assign m_axis_tlast  = res_reg.done;

    // walk state sanity
    a_phase_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(phase_reg))
        else $error("parse phase not one-hot");

    a_left_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_left_reg <= tcp_opt_pkg::MAX_OPT_LEN)
        else $error("bytes left beyond option area limit");

    a_body_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == tcp_opt_pkg::PH_BODY |-> body_cnt_reg != '0)
        else $error("option body phase with no bytes to come");

    a_done_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && res_next.done |=> phase_reg == tcp_opt_pkg::PH_STOP)
        else $error("walk not stopped after final event");

    a_ignored_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == tcp_opt_pkg::EV_IGNORED |-> m_axis_tlast)
        else $error("ignored byte without done");

endmodule
